/* src/tlt_pkg.sv */
// Shared widths, configuration codes and cell state types for the trilateration block.
package tlt_pkg;

	localparam int FRAC_BITS = 8;
	localparam int COORD_W = 24;
	localparam int RANGE_W = 23;
	localparam int BEARING_W = 16;
	localparam int FL_W = 15;
	localparam int FW_W = 15;
	localparam int BM_W = 12;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_ADDR_W-1:0] REG_FIELD_LENGTH = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_FIELD_WIDTH = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_BOUND_MARGIN = 2'd2;

	localparam logic [FL_W-1:0] FL_RESET = 15'd1800;
	localparam logic [FW_W-1:0] FW_RESET = 15'd1200;
	localparam logic [BM_W-1:0] BM_RESET = 12'd60;

	localparam int SQ_ARG_W = 50;
	localparam int SQ_ROOT_W = 25;
	localparam int SQ_REM_W = 26;
	localparam int SQ_STEPS = 25;

	localparam int DV_D_W = 59;
	localparam int DV_V_W = 26;
	localparam int DV_REM_W = 26;
	localparam int DV_Q_W = 33;
	localparam int DPAR_STEPS = 33;
	localparam int POS_STEPS = 26;

	localparam int PIPE_LAT = 120;

	typedef struct packed {
		logic [SQ_REM_W-1:0] rem;
		logic [SQ_ROOT_W-1:0] root;
		logic [SQ_ARG_W-1:0] arg;
	} sq_t;

	typedef struct packed {
		logic [DV_REM_W-1:0] rem;
		logic [DV_D_W-1:0] d;
		logic [DV_V_W-1:0] v;
		logic [DV_Q_W-1:0] q;
	} dv_t;

endpackage

/* src/tlt_sqrt_cell.sv */
// One registered step of a restoring integer square root, two argument bits per step.
module tlt_sqrt_cell (
	input logic clk,
	input tlt_pkg::sq_t din,
	output tlt_pkg::sq_t dout
);

	logic [tlt_pkg::SQ_REM_W+1:0] rs;
	logic [tlt_pkg::SQ_REM_W+1:0] trial;
	logic ge;

	always_comb begin
		rs = {din.rem, din.arg[tlt_pkg::SQ_ARG_W-1 -: 2]};
		trial = {1'b0, din.root, 2'b01};
		ge = (rs >= trial);
	end

	always_ff @(posedge clk) begin
		dout.rem <= ge ? tlt_pkg::SQ_REM_W'(rs - trial) : tlt_pkg::SQ_REM_W'(rs);
		dout.root <= {din.root[tlt_pkg::SQ_ROOT_W-2:0], ge};
		dout.arg <= {din.arg[tlt_pkg::SQ_ARG_W-3:0], 2'b00};
	end

endmodule

/* src/tlt_div_cell.sv */
// One registered step of a restoring unsigned division, one quotient bit per step.
module tlt_div_cell (
	input logic clk,
	input tlt_pkg::dv_t din,
	output tlt_pkg::dv_t dout
);

	logic [tlt_pkg::DV_REM_W:0] rn;
	logic ge;

	always_comb begin
		rn = {din.rem, din.d[tlt_pkg::DV_D_W-1]};
		ge = (rn >= {1'b0, din.v});
	end

	always_ff @(posedge clk) begin
		dout.rem <= ge ? tlt_pkg::DV_REM_W'(rn - {1'b0, din.v}) : tlt_pkg::DV_REM_W'(rn);
		dout.d <= {din.d[tlt_pkg::DV_D_W-2:0], 1'b0};
		dout.v <= din.v;
		dout.q <= {din.q[tlt_pkg::DV_Q_W-2:0], ge};
	end

endmodule

/* src/two_landmark_trilateration_top.sv */
// Top level: observer position from two landmark circles as a pipeline of arithmetic cells.
//
// An item is taken at each rising edge with start high and busy low. Busy is always
// low, so a new landmark pair may be started in every cycle, one per cycle sustained.
// Each result appears on pos_x, pos_y and pos_valid for one cycle with done high.
// Results leave in the order of their starts and
// the receiver must take each one in that cycle; it cannot hold results off.
// The pipeline is built from bit-serial cell rows: 25 square-root cells for the
// baseline length, 33 division cells for the along-baseline distance, 25 square-root
// cells for the orthogonal offset and two rows of 26 division cells for the two coordinates,
// plus 11 stages of capture, multiply, add, division setup, saturation and bound check.
// The configuration channel takes a transaction whenever cfg_valid is high; the
// registers must only be written while no item is in flight.
// Reset clears the in-flight marks and loads the field size and margin defaults;
// items in flight at reset are dropped.
module two_landmark_trilateration_top (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [tlt_pkg::COORD_W-1:0] first_x,
	input logic signed [tlt_pkg::COORD_W-1:0] first_y,
	input logic [tlt_pkg::RANGE_W-1:0] first_range,
	input logic signed [tlt_pkg::BEARING_W-1:0] first_bearing,
	input logic signed [tlt_pkg::COORD_W-1:0] second_x,
	input logic signed [tlt_pkg::COORD_W-1:0] second_y,
	input logic [tlt_pkg::RANGE_W-1:0] second_range,
	input logic signed [tlt_pkg::BEARING_W-1:0] second_bearing,
	output logic done,
	output logic signed [tlt_pkg::COORD_W-1:0] pos_x,
	output logic signed [tlt_pkg::COORD_W-1:0] pos_y,
	output logic pos_valid,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [tlt_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input logic [tlt_pkg::CFG_DATA_W-1:0] cfg_data
);

	typedef struct packed {
		logic [23:0] xa;
		logic [23:0] ya;
		logic [24:0] dx;
		logic [24:0] dy;
		logic [22:0] ra;
		logic [45:0] ra2;
		logic s;
		logic [50:0] num;
		logic zero;
	} sa_t;

	typedef struct packed {
		logic [23:0] xa;
		logic [23:0] ya;
		logic [24:0] dx;
		logic [24:0] dy;
		logic [22:0] ra;
		logic [45:0] ra2;
		logic s;
		logic neg;
		logic ovf;
		logic zero;
		logic [24:0] len;
	} sb_t;

	typedef struct packed {
		logic [23:0] xa;
		logic [23:0] ya;
		logic [24:0] dx;
		logic [24:0] dy;
		logic s;
		logic [33:0] dpar;
		logic [24:0] len;
		logic zero;
	} sc_t;

	typedef struct packed {
		logic [23:0] xa;
		logic [23:0] ya;
		logic negx;
		logic negy;
		logic ovfx;
		logic ovfy;
		logic zero;
	} sd_t;

	logic [tlt_pkg::FL_W-1:0] fl_q;
	logic [tlt_pkg::FW_W-1:0] fw_q;
	logic [tlt_pkg::BM_W-1:0] bm_q;
	logic [tlt_pkg::PIPE_LAT-1:0] vld_q;

	// Stage 1: input capture.
	logic signed [23:0] xa_s1, ya_s1;
	logic signed [24:0] dx_s1, dy_s1;
	logic [22:0] ra_s1, rb_s1;
	logic s_s1;

	// Stage 2: squares.
	logic [24:0] adx_f, ady_f;
	logic signed [23:0] xa_s2, ya_s2;
	logic signed [24:0] dx_s2, dy_s2;
	logic [22:0] ra_s2;
	logic s_s2;
	logic [47:0] dx2_s2, dy2_s2;
	logic [45:0] ra2_s2, rb2_s2;

	// Stage 3: baseline length squared and the numerator of d_par.
	logic [48:0] l2_f;
	logic [48:0] l2_s3;
	sa_t sa_s3;
	tlt_pkg::sq_t sq_a [0:tlt_pkg::SQ_STEPS];
	sa_t sa_q [0:tlt_pkg::SQ_STEPS-1];

	// Stage 4: division setup for d_par.
	sa_t a_f;
	logic [24:0] len_f;
	logic [50:0] nmag_f;
	logic [50:0] dd_f;
	logic [25:0] v_f;
	logic ovf_f;
	tlt_pkg::dv_t dva_s4;
	sb_t sb_s4;
	tlt_pkg::dv_t dv_a [0:tlt_pkg::DPAR_STEPS];
	sb_t sb_q [0:tlt_pkg::DPAR_STEPS-1];

	// Stages 5 to 7: saturation, discriminant.
	sb_t b_f;
	logic sat_f;
	logic [32:0] mag_f;
	sc_t sc_s5, sc_s6, sc_s7;
	logic [45:0] ra2_s5, ra2_s6;
	logic [22:0] dp_s5;
	logic cond_s5, cond_s6;
	logic [45:0] dp2_s6;
	logic [45:0] arg_s7;
	tlt_pkg::sq_t sq_b [0:tlt_pkg::SQ_STEPS];
	sc_t sc_q [0:tlt_pkg::SQ_STEPS-1];

	// Stages 8 to 10: products, sums, division setup for the coordinates.
	sc_t c_f;
	logic [23:0] dorth_f;
	logic signed [23:0] so_f;
	logic signed [16:0] hi_f;
	logic signed [17:0] lo_f;
	logic signed [24:0] cdx_f, cdy_f;
	logic signed [41:0] p1_s8, p3_s8;
	logic signed [42:0] p2_s8, p4_s8;
	logic signed [48:0] p5_s8, p6_s8;
	logic [23:0] xa_s8, ya_s8, xa_s9, ya_s9;
	logic [24:0] len_s8, len_s9;
	logic zero_s8, zero_s9;
	logic signed [59:0] nx_s9, ny_s9;
	logic [59:0] ax_f, ay_f;
	logic [58:0] ddx_f, ddy_f;
	logic ovfx_f, ovfy_f;
	tlt_pkg::dv_t dvx_s10, dvy_s10;
	sd_t sd_s10;
	tlt_pkg::dv_t dv_x [0:tlt_pkg::POS_STEPS];
	tlt_pkg::dv_t dv_y [0:tlt_pkg::POS_STEPS];
	sd_t sd_q [0:tlt_pkg::POS_STEPS-1];

	// Stage 11: coordinates and bound check.
	sd_t e_f;
	logic [25:0] qx_f, qy_f;
	logic [26:0] sx_f, sy_f;
	logic [27:0] x_f, y_f;
	logic [27:0] mx_f, my_f;
	logic [23:0] bx_f, by_f;
	logic outx_f, outy_f, ok_f;
	logic [23:0] pos_x_q, pos_y_q;
	logic pos_valid_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign done = vld_q[tlt_pkg::PIPE_LAT-1];
	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;
	assign pos_valid = pos_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fl_q <= tlt_pkg::FL_RESET;
			fw_q <= tlt_pkg::FW_RESET;
			bm_q <= tlt_pkg::BM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_addr)
				tlt_pkg::REG_FIELD_LENGTH: fl_q <= cfg_data[tlt_pkg::FL_W-1:0];
				tlt_pkg::REG_FIELD_WIDTH: fw_q <= cfg_data[tlt_pkg::FW_W-1:0];
				tlt_pkg::REG_BOUND_MARGIN: bm_q <= cfg_data[tlt_pkg::BM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[tlt_pkg::PIPE_LAT-2:0], start && !busy};
		end
	end

	always_ff @(posedge clk) begin
		xa_s1 <= first_x;
		ya_s1 <= first_y;
		dx_s1 <= 25'(second_x) - 25'(first_x);
		dy_s1 <= 25'(second_y) - 25'(first_y);
		ra_s1 <= first_range;
		rb_s1 <= second_range;
		s_s1 <= (second_bearing > first_bearing);
	end

	always_comb begin
		adx_f = dx_s1[24] ? (~dx_s1 + 25'd1) : dx_s1;
		ady_f = dy_s1[24] ? (~dy_s1 + 25'd1) : dy_s1;
	end

	always_ff @(posedge clk) begin
		xa_s2 <= xa_s1;
		ya_s2 <= ya_s1;
		dx_s2 <= dx_s1;
		dy_s2 <= dy_s1;
		ra_s2 <= ra_s1;
		s_s2 <= s_s1;
		dx2_s2 <= adx_f[23:0] * adx_f[23:0];
		dy2_s2 <= ady_f[23:0] * ady_f[23:0];
		ra2_s2 <= ra_s1 * ra_s1;
		rb2_s2 <= rb_s1 * rb_s1;
	end

	assign l2_f = {1'b0, dx2_s2} + {1'b0, dy2_s2};

	always_ff @(posedge clk) begin
		l2_s3 <= l2_f;
		sa_s3.xa <= xa_s2;
		sa_s3.ya <= ya_s2;
		sa_s3.dx <= dx_s2;
		sa_s3.dy <= dy_s2;
		sa_s3.ra <= ra_s2;
		sa_s3.ra2 <= ra2_s2;
		sa_s3.s <= s_s2;
		sa_s3.num <= {2'b00, l2_f} + {5'b0, ra2_s2} - {5'b0, rb2_s2};
		sa_s3.zero <= (l2_f == '0);
	end

	assign sq_a[0].rem = '0;
	assign sq_a[0].root = '0;
	assign sq_a[0].arg = {1'b0, l2_s3};

	for (genvar i = 0; i < tlt_pkg::SQ_STEPS; i++) begin : g_sqa
		tlt_sqrt_cell u_cell (.clk(clk), .din(sq_a[i]), .dout(sq_a[i+1]));
	end

	always_ff @(posedge clk) begin
		sa_q[0] <= sa_s3;
		for (int i = 1; i < tlt_pkg::SQ_STEPS; i++) begin
			sa_q[i] <= sa_q[i-1];
		end
	end

	always_comb begin
		a_f = sa_q[tlt_pkg::SQ_STEPS-1];
		len_f = sq_a[tlt_pkg::SQ_STEPS].root;
		nmag_f = a_f.num[50] ? (~a_f.num + 51'd1) : a_f.num;
		dd_f = nmag_f + {26'b0, len_f};
		v_f = {len_f, 1'b0};
		ovf_f = ({8'b0, dd_f[50:33]} >= v_f);
	end

	always_ff @(posedge clk) begin
		dva_s4.rem <= ovf_f ? '0 : {8'b0, dd_f[50:33]};
		dva_s4.d <= {dd_f[32:0], 26'b0};
		dva_s4.v <= v_f;
		dva_s4.q <= '0;
		sb_s4.xa <= a_f.xa;
		sb_s4.ya <= a_f.ya;
		sb_s4.dx <= a_f.dx;
		sb_s4.dy <= a_f.dy;
		sb_s4.ra <= a_f.ra;
		sb_s4.ra2 <= a_f.ra2;
		sb_s4.s <= a_f.s;
		sb_s4.neg <= a_f.num[50];
		sb_s4.ovf <= ovf_f;
		sb_s4.zero <= a_f.zero;
		sb_s4.len <= len_f;
	end

	assign dv_a[0] = dva_s4;

	for (genvar i = 0; i < tlt_pkg::DPAR_STEPS; i++) begin : g_dva
		tlt_div_cell u_cell (.clk(clk), .din(dv_a[i]), .dout(dv_a[i+1]));
	end

	always_ff @(posedge clk) begin
		sb_q[0] <= sb_s4;
		for (int i = 1; i < tlt_pkg::DPAR_STEPS; i++) begin
			sb_q[i] <= sb_q[i-1];
		end
	end

	always_comb begin
		b_f = sb_q[tlt_pkg::DPAR_STEPS-1];
		sat_f = b_f.ovf | (dv_a[tlt_pkg::DPAR_STEPS].q[32] & (|dv_a[tlt_pkg::DPAR_STEPS].q[31:0]));
		mag_f = sat_f ? {1'b1, 32'b0} : dv_a[tlt_pkg::DPAR_STEPS].q;
	end

	always_ff @(posedge clk) begin
		sc_s5.xa <= b_f.xa;
		sc_s5.ya <= b_f.ya;
		sc_s5.dx <= b_f.dx;
		sc_s5.dy <= b_f.dy;
		sc_s5.s <= b_f.s;
		sc_s5.dpar <= b_f.neg ? (~{1'b0, mag_f} + 34'd1) : {1'b0, mag_f};
		sc_s5.len <= b_f.len;
		sc_s5.zero <= b_f.zero;
		ra2_s5 <= b_f.ra2;
		dp_s5 <= mag_f[22:0];
		cond_s5 <= (mag_f < {10'b0, b_f.ra});
	end

	always_ff @(posedge clk) begin
		sc_s6 <= sc_s5;
		ra2_s6 <= ra2_s5;
		cond_s6 <= cond_s5;
		dp2_s6 <= dp_s5 * dp_s5;
	end

	always_ff @(posedge clk) begin
		sc_s7 <= sc_s6;
		arg_s7 <= cond_s6 ? (ra2_s6 - dp2_s6) : '0;
	end

	assign sq_b[0].rem = '0;
	assign sq_b[0].root = '0;
	assign sq_b[0].arg = {4'b0, arg_s7};

	for (genvar i = 0; i < tlt_pkg::SQ_STEPS; i++) begin : g_sqb
		tlt_sqrt_cell u_cell (.clk(clk), .din(sq_b[i]), .dout(sq_b[i+1]));
	end

	always_ff @(posedge clk) begin
		sc_q[0] <= sc_s7;
		for (int i = 1; i < tlt_pkg::SQ_STEPS; i++) begin
			sc_q[i] <= sc_q[i-1];
		end
	end

	always_comb begin
		c_f = sc_q[tlt_pkg::SQ_STEPS-1];
		dorth_f = {1'b0, sq_b[tlt_pkg::SQ_STEPS].root[22:0]};
		so_f = c_f.s ? dorth_f : (~dorth_f + 24'd1);
		hi_f = c_f.dpar[33:17];
		lo_f = {1'b0, c_f.dpar[16:0]};
		cdx_f = c_f.dx;
		cdy_f = c_f.dy;
	end

	always_ff @(posedge clk) begin
		p1_s8 <= hi_f * cdx_f;
		p2_s8 <= lo_f * cdx_f;
		p3_s8 <= hi_f * cdy_f;
		p4_s8 <= lo_f * cdy_f;
		p5_s8 <= so_f * cdy_f;
		p6_s8 <= so_f * cdx_f;
		xa_s8 <= c_f.xa;
		ya_s8 <= c_f.ya;
		len_s8 <= c_f.len;
		zero_s8 <= c_f.zero;
	end

	always_ff @(posedge clk) begin
		nx_s9 <= (60'(p1_s8) <<< 17) + 60'(p2_s8) - 60'(p5_s8);
		ny_s9 <= (60'(p3_s8) <<< 17) + 60'(p4_s8) + 60'(p6_s8);
		xa_s9 <= xa_s8;
		ya_s9 <= ya_s8;
		len_s9 <= len_s8;
		zero_s9 <= zero_s8;
	end

	always_comb begin
		ax_f = nx_s9[59] ? (~nx_s9 + 60'd1) : nx_s9;
		ay_f = ny_s9[59] ? (~ny_s9 + 60'd1) : ny_s9;
		ddx_f = ax_f[58:0] + {35'b0, len_s9[24:1]};
		ddy_f = ay_f[58:0] + {35'b0, len_s9[24:1]};
		ovfx_f = (ddx_f[58:26] >= {8'b0, len_s9});
		ovfy_f = (ddy_f[58:26] >= {8'b0, len_s9});
	end

	always_ff @(posedge clk) begin
		dvx_s10.rem <= ovfx_f ? '0 : {1'b0, ddx_f[50:26]};
		dvx_s10.d <= {ddx_f[25:0], 33'b0};
		dvx_s10.v <= {1'b0, len_s9};
		dvx_s10.q <= '0;
		dvy_s10.rem <= ovfy_f ? '0 : {1'b0, ddy_f[50:26]};
		dvy_s10.d <= {ddy_f[25:0], 33'b0};
		dvy_s10.v <= {1'b0, len_s9};
		dvy_s10.q <= '0;
		sd_s10.xa <= xa_s9;
		sd_s10.ya <= ya_s9;
		sd_s10.negx <= nx_s9[59];
		sd_s10.negy <= ny_s9[59];
		sd_s10.ovfx <= ovfx_f;
		sd_s10.ovfy <= ovfy_f;
		sd_s10.zero <= zero_s9;
	end

	assign dv_x[0] = dvx_s10;
	assign dv_y[0] = dvy_s10;

	for (genvar i = 0; i < tlt_pkg::POS_STEPS; i++) begin : g_dvxy
		tlt_div_cell u_cell_x (.clk(clk), .din(dv_x[i]), .dout(dv_x[i+1]));
		tlt_div_cell u_cell_y (.clk(clk), .din(dv_y[i]), .dout(dv_y[i+1]));
	end

	always_ff @(posedge clk) begin
		sd_q[0] <= sd_s10;
		for (int i = 1; i < tlt_pkg::POS_STEPS; i++) begin
			sd_q[i] <= sd_q[i-1];
		end
	end

	always_comb begin
		e_f = sd_q[tlt_pkg::POS_STEPS-1];
		qx_f = dv_x[tlt_pkg::POS_STEPS].q[25:0];
		qy_f = dv_y[tlt_pkg::POS_STEPS].q[25:0];
		sx_f = e_f.negx ? (~{1'b0, qx_f} + 27'd1) : {1'b0, qx_f};
		sy_f = e_f.negy ? (~{1'b0, qy_f} + 27'd1) : {1'b0, qy_f};
		x_f = {{4{e_f.xa[23]}}, e_f.xa} + {sx_f[26], sx_f};
		y_f = {{4{e_f.ya[23]}}, e_f.ya} + {sy_f[26], sy_f};
		mx_f = x_f[27] ? (~x_f + 28'd1) : x_f;
		my_f = y_f[27] ? (~y_f + 28'd1) : y_f;
		bx_f = {1'b0, fl_q, 8'b0} + {3'b0, bm_q, 9'b0};
		by_f = {1'b0, fw_q, 8'b0} + {3'b0, bm_q, 9'b0};
		outx_f = ({mx_f, 1'b0} > {5'b0, bx_f});
		outy_f = ({my_f, 1'b0} > {5'b0, by_f});
		ok_f = !e_f.zero && !e_f.ovfx && !e_f.ovfy && !outx_f && !outy_f;
	end

	always_ff @(posedge clk) begin
		pos_x_q <= ok_f ? x_f[23:0] : '0;
		pos_y_q <= ok_f ? y_f[23:0] : '0;
		pos_valid_q <= ok_f;
	end

endmodule

/* bench/testbench.sv */
// Testbench for the two landmark trilateration block with its scoreboard.

class position_scoreboard;
	typedef struct {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic valid;
	} fix_t;

	logic [14:0] field_length;
	logic [14:0] field_width;
	logic [11:0] bound_margin;
	fix_t pending[$];
	int mismatches;
	int fixes;
	int valid_fixes;
	int pairs;

	function new();
		field_length = tlt_pkg::FL_RESET;
		field_width = tlt_pkg::FW_RESET;
		bound_margin = tlt_pkg::BM_RESET;
		mismatches = 0;
		fixes = 0;
		valid_fixes = 0;
		pairs = 0;
	endfunction

	function void write_reg(logic [1:0] addr, logic [14:0] data);
		case (addr)
			tlt_pkg::REG_FIELD_LENGTH: field_length = data;
			tlt_pkg::REG_FIELD_WIDTH: field_width = data;
			tlt_pkg::REG_BOUND_MARGIN: bound_margin = data[11:0];
			default: ;
		endcase
	endfunction

	static function longint unsigned mag(longint v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	static function longint unsigned int_root(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	static function longint round_div(longint num, longint unsigned den);
		longint unsigned q;
		q = (mag(num) + den / 2) / den;
		return num < 0 ? -longint'(q) : longint'(q);
	endfunction

	function void note_pair(logic signed [23:0] xa, logic signed [23:0] ya,
			logic [22:0] ra_in, logic signed [15:0] aa,
			logic signed [23:0] xb, logic signed [23:0] yb,
			logic [22:0] rb_in, logic signed [15:0] ab);
		longint dx, dy, l2, len, num, dpar, so, x, y, ra, rb;
		longint unsigned dorth, bx, by;
		fix_t f;
		f = '{x: '0, y: '0, valid: 1'b0};
		pairs++;
		ra = ra_in;
		rb = rb_in;
		dx = longint'(xb) - longint'(xa);
		dy = longint'(yb) - longint'(ya);
		l2 = dx * dx + dy * dy;
		if (l2 != 0) begin
			len = int_root(l2);
			num = l2 + ra * ra - rb * rb;
			dpar = round_div(num, 2 * len);
			if (dpar > (longint'(1) << 32))
				dpar = longint'(1) << 32;
			if (dpar < -(longint'(1) << 32))
				dpar = -(longint'(1) << 32);
			dorth = 0;
			if (mag(dpar) < ra)
				dorth = int_root(ra * ra - dpar * dpar);
			so = (ab > aa) ? longint'(dorth) : -longint'(dorth);
			x = longint'(xa) + round_div(dpar * dx - so * dy, len);
			y = longint'(ya) + round_div(dpar * dy + so * dx, len);
			bx = (longint'(field_length) << 8) + (longint'(bound_margin) << 9);
			by = (longint'(field_width) << 8) + (longint'(bound_margin) << 9);
			if (!(2 * mag(x) > bx || 2 * mag(y) > by))
				f = '{x: x[23:0], y: y[23:0], valid: 1'b1};
		end
		pending.push_back(f);
	endfunction

	function void check_fix(logic signed [23:0] x, logic signed [23:0] y, logic valid);
		fix_t e;
		fixes++;
		if (valid)
			valid_fixes++;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: unexpected result x=%0d y=%0d valid=%0b", x, y, valid);
			return;
		end
		e = pending.pop_front();
		if (e.x !== x || e.y !== y || e.valid !== valid) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: result %0d expected x=%0d y=%0d valid=%0b got x=%0d y=%0d valid=%0b",
					fixes, e.x, e.y, e.valid, x, y, valid);
		end
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [tlt_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [tlt_pkg::COORD_W-1:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
	logic [tlt_pkg::RANGE_W-1:0] first_range = '0, second_range = '0;
	logic signed [tlt_pkg::BEARING_W-1:0] first_bearing = '0, second_bearing = '0;
	logic done;
	logic signed [tlt_pkg::COORD_W-1:0] pos_x, pos_y;
	logic pos_valid;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [tlt_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [tlt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	position_scoreboard sb = new();
	int quiet_cycles = 0;
	bit no_idle = 1'b0;

	two_landmark_trilateration_top DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_pair(first_x, first_y, first_range, first_bearing,
					second_x, second_y, second_range, second_bearing);
			if (done)
				sb.check_fix(pos_x, pos_y, pos_valid);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_addr, cfg_data);
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("ERROR: watchdog expired");
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_pair(logic signed [23:0] xa, logic signed [23:0] ya, logic [22:0] ra,
			logic signed [15:0] aa, logic signed [23:0] xb, logic signed [23:0] yb,
			logic [22:0] rb, logic signed [15:0] ab);
		if (!no_idle && $urandom_range(99) < 5) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		first_x <= xa;
		first_y <= ya;
		first_range <= ra;
		first_bearing <= aa;
		second_x <= xb;
		second_y <= yb;
		second_range <= rb;
		second_bearing <= ab;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [tlt_pkg::CFG_ADDR_W-1:0] addr,
			logic [tlt_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_field(logic [14:0] fl, logic [14:0] fw, logic [14:0] bm);
		drain();
		write_reg(tlt_pkg::REG_FIELD_LENGTH, fl);
		write_reg(tlt_pkg::REG_FIELD_WIDTH, fw);
		write_reg(tlt_pkg::REG_BOUND_MARGIN, bm);
		write_reg(REG_UNUSED, 15'($urandom));
	endtask

	function automatic logic signed [15:0] rand_bearing();
		return 16'($signed($urandom_range(36000)) - 18000);
	endfunction

	// Random landmarks and an observer near the field, ranges near the true distances.
	task automatic send_scene();
		int ox, oy, ax, ay, bx, by, noise;
		real da, db;
		ox = $signed($urandom_range(600000)) - 300000;
		oy = $signed($urandom_range(400000)) - 200000;
		ax = $signed($urandom_range(1000000)) - 500000;
		ay = $signed($urandom_range(1000000)) - 500000;
		bx = $signed($urandom_range(1000000)) - 500000;
		by = $signed($urandom_range(1000000)) - 500000;
		noise = $urandom_range(3) == 0 ? 4000 : 200;
		da = $sqrt(real'(ax - ox) ** 2 + real'(ay - oy) ** 2);
		db = $sqrt(real'(bx - ox) ** 2 + real'(by - oy) ** 2);
		send_pair(24'(ax), 24'(ay), 23'($rtoi(da) + $urandom_range(noise)), rand_bearing(),
			24'(bx), 24'(by), 23'($rtoi(db) + $urandom_range(noise)), rand_bearing());
	endtask

	task automatic send_noise();
		send_pair(24'($urandom), 24'($urandom), 23'($urandom), 16'($urandom),
			24'($urandom), 24'($urandom), 23'($urandom), 16'($urandom));
	endtask

	task automatic random_run(int n);
		for (int i = 0; i < n; i++) begin
			no_idle = (i >= n / 3 && i < n / 2);
			if ($urandom_range(9) < 8)
				send_scene();
			else
				send_noise();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pair(0, 0, 2560, 0, 0, 0, 2560, 100);
		send_pair(25600, 0, 20000, 0, 25600, 0, 0, 0);
		send_pair(0, 0, 12800, -100, 25600, 0, 12800, 100);
		send_pair(0, 0, 12800, 100, 25600, 0, 12800, -100);
		send_pair(0, 0, 12800, 500, 25600, 0, 12800, 500);
		send_pair(0, 0, 1000, 0, 25600, 0, 1000, 1);
		send_pair(-76800, -51200, 100000, -18000, 76800, 51200, 120000, 18000);
		send_pair(0, 0, 50000, -32768, 0, 30000, 40000, 32767);
		send_pair(24'sh7fffff, 24'sh7fffff, 23'h7fffff, 18000,
			24'sh800000, 24'sh800000, 23'h7fffff, -18000);
		send_pair(24'sh800000, 24'sh7fffff, 0, 0, 24'sh7fffff, 24'sh800000, 0, 1);
		send_pair(24'sh800000, 0, 23'h7fffff, 0, 24'sh7fffff, 0, 0, 1);
		send_pair(0, 0, 0, 0, 1, 0, 23'h7fffff, 1);
		send_pair(230400, 0, 1000, 0, 230400, 1, 1000, 0);
		send_pair(24'sh7fffff, 0, 23'h7fffff, 0, 24'sh7fffff, 1, 23'h7fffff, 0);
		random_run(350);

		// Hold off until the pipeline is empty before continuing.
		drain();
		repeat ($urandom_range(1, 20)) @(posedge clk);
		random_run(50);

		set_field(15'd0, 15'd0, 15'd0);
		send_pair(0, 0, 12800, 0, 25600, 0, 12800, 1);
		send_pair(0, 0, 12800, 1, 25600, 0, 12800, 0);
		random_run(150);

		set_field(15'h7fff, 15'h7fff, 15'h7fff);
		send_pair(0, 0, 5000000, 0, 8000000, 0, 5000000, 1);
		random_run(250);

		set_field(15'($urandom_range(600, 3000)), 15'($urandom_range(400, 2000)),
			15'($urandom));
		random_run(150);

		set_field(tlt_pkg::FL_RESET, tlt_pkg::FW_RESET, 15'h7000 | tlt_pkg::BM_RESET);
		random_run(180);

		drain();
		repeat (tlt_pkg::PIPE_LAT + 10) @(posedge clk);
		if (sb.pending.size() != 0) begin
			sb.mismatches += sb.pending.size();
			$display("ERROR: %0d results never arrived", sb.pending.size());
		end
		$display("Covered %0d landmark pairs, %0d results (%0d valid) over five field settings.",
			sb.pairs, sb.fixes, sb.valid_fixes);
		$display("Mismatches: %0d", sb.mismatches);
		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
